### hdl/nnse_pkg.sv
// Shared constants, types and codes for the nearest-neighbour search core.
// No dependencies; imported by nearest_neighbor_sq_euclid_core.
package nnse_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int MAX_DIMS    = 64;
  localparam int COEF_WIDTH  = 16;

  localparam int IDX_W    = 6;
  localparam int CNT_W    = 7;
  localparam int ENT_W    = $clog2(MAX_ENTRIES);
  localparam int DIM_W    = $clog2(MAX_DIMS);
  localparam int ADDR_W   = $clog2(MAX_ENTRIES * MAX_DIMS);
  localparam int DIFF_W   = COEF_WIDTH + 1;
  localparam int SQ_W     = 2 * COEF_WIDTH;
  localparam int DIST_W   = 39;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 48;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = CNT_W;

  localparam logic [CFG_ADDR_W-1:0] REG_NUM_ENTRIES = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_NUM_DIMS    = 1'b1;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_DRAIN,
    ST_RESULT
  } state_t;

  // tag carried alongside each coefficient through the distance pipeline
  typedef struct packed {
    logic             first;
    logic             last;
    logic             final_ent;
    logic [ENT_W-1:0] ent;
  } tag_t;

endpackage

### hdl/nearest_neighbor_sq_euclid_core.sv
// Nearest-neighbour search core: reference table and query buffer in on-chip RAM,
// distance pipeline, running minimum and result register. Depends on nnse_pkg.
//
// Reference writes and query coefficients are accepted back to back while idle.
// An item with operation = query and tlast set starts the search: the core walks
// the table through its single read port, one coefficient per cycle, and each
// coefficient passes the read, difference, square and accumulate registers
// before the running minimum is updated; the result is offered after the last
// entry's compare. No input item is taken during a search. A dimension count of
// zero skips the walk and answers index 0, distance 0. RAM contents are not
// cleared at reset; reading unwritten locations gives no defined result.
module nearest_neighbor_sq_euclid_core
  import nnse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [5:0] entry_index, [11:6] dim_index, [27:12] coefficient, [31:28] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                  s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [5:0] nearest_index, [44:6] least_distance, [47:45] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  state_t state, state_next;

  logic [CNT_W-1:0] num_entries, num_dims;
  logic [ENT_W-1:0] ent_last, seq_e;
  logic [DIM_W-1:0] dim_last, seq_d;

  logic                         in_fire, issue, load_out, start, seq_end;
  logic [IDX_W-1:0]             in_entry, in_dim;
  logic signed [COEF_WIDTH-1:0] in_coef;
  logic                         in_ent_ok, in_dim_ok;

  logic signed [COEF_WIDTH-1:0] ref_mem [0:MAX_ENTRIES*MAX_DIMS-1];
  logic signed [COEF_WIDTH-1:0] qry_mem [0:MAX_DIMS-1];
  logic signed [COEF_WIDTH-1:0] ref_rd, qry_rd;
  logic [ADDR_W-1:0]            ref_waddr, ref_raddr;

  logic                     p1_valid, p2_valid, p3_valid, pa_valid;
  tag_t                     tag0, p1_tag, p2_tag, p3_tag, pa_tag;
  logic signed [DIFF_W-1:0] p2_diff;
  logic [DIFF_W-1:0]        mag;
  logic [SQ_W-1:0]          p3_sq;
  logic [DIST_W-1:0]        acc, acc_next;
  logic [DIST_W:0]          acc_sum;
  logic                     cmp_final;

  logic [ENT_W-1:0]  best_idx;
  logic [DIST_W-1:0] best_dist;
  logic              out_valid;
  logic [IDX_W-1:0]  out_idx;
  logic [DIST_W-1:0] out_dist;

  assign in_entry  = s_axis_tdata[IDX_W-1:0];
  assign in_dim    = s_axis_tdata[2*IDX_W-1:IDX_W];
  assign in_coef   = s_axis_tdata[2*IDX_W+COEF_WIDTH-1:2*IDX_W];
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_ent_ok = 32'(in_entry) < MAX_ENTRIES;
  assign in_dim_ok = 32'(in_dim) < MAX_DIMS;
  assign start     = in_fire && (s_axis_tuser == OP_QUERY) && s_axis_tlast;
  assign seq_end   = (seq_d == dim_last) && (seq_e == ent_last);
  assign cmp_final = pa_valid && pa_tag.final_ent;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      num_entries <= CNT_W'(1);
      num_dims    <= CNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_NUM_ENTRIES: num_entries <= cfg_data;
        REG_NUM_DIMS:    num_dims    <= cfg_data;
        default: ;
      endcase
    end
  end

  // state machine
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = (num_dims == '0) ? ST_RESULT : ST_SEARCH;
      end
      ST_SEARCH: begin
        if (seq_end) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (cmp_final) state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid || m_axis_tready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    unique case (state)
      ST_IDLE:   s_axis_tready = 1'b1;
      ST_SEARCH: issue = 1'b1;
      ST_DRAIN:  ;
      ST_RESULT: load_out = !out_valid || m_axis_tready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // table walk sequencer
  always_ff @(posedge clk) begin
    if (start) begin
      seq_e <= '0;
      seq_d <= '0;
      if (num_entries == '0)
        ent_last <= '0;
      else if (32'(num_entries) > MAX_ENTRIES)
        ent_last <= ENT_W'(MAX_ENTRIES - 1);
      else
        ent_last <= ENT_W'(num_entries - CNT_W'(1));
      if (32'(num_dims) > MAX_DIMS)
        dim_last <= DIM_W'(MAX_DIMS - 1);
      else
        dim_last <= DIM_W'(num_dims - CNT_W'(1));
    end else if (issue) begin
      if (seq_d == dim_last) begin
        seq_d <= '0;
        seq_e <= seq_e + ENT_W'(1);
      end else begin
        seq_d <= seq_d + DIM_W'(1);
      end
    end
  end

  // memories
  assign ref_waddr = ADDR_W'(ADDR_W'(in_entry) * ADDR_W'(MAX_DIMS)) + ADDR_W'(in_dim);
  assign ref_raddr = ADDR_W'(ADDR_W'(seq_e) * ADDR_W'(MAX_DIMS)) + ADDR_W'(seq_d);

  always_ff @(posedge clk) begin
    if (in_fire && (s_axis_tuser == OP_WRITE) && in_ent_ok && in_dim_ok)
      ref_mem[ref_waddr] <= in_coef;
    ref_rd <= ref_mem[ref_raddr];
  end

  always_ff @(posedge clk) begin
    if (in_fire && (s_axis_tuser == OP_QUERY) && in_dim_ok)
      qry_mem[DIM_W'(in_dim)] <= in_coef;
    qry_rd <= qry_mem[seq_d];
  end

  // distance pipeline: read, difference, square, accumulate, compare
  always_comb begin
    tag0.first     = (seq_d == '0);
    tag0.last      = (seq_d == dim_last);
    tag0.final_ent = seq_end;
    tag0.ent       = seq_e;
  end

  assign mag     = p2_diff[DIFF_W-1] ? DIFF_W'(-p2_diff) : DIFF_W'(p2_diff);
  assign acc_sum = {1'b0, acc} + (DIST_W+1)'(p3_sq);

  always_comb begin
    if (p3_tag.first)
      acc_next = DIST_W'(p3_sq);
    else if (acc_sum[DIST_W])
      acc_next = DIST_MAX;
    else
      acc_next = acc_sum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      pa_valid <= 1'b0;
    end else begin
      p1_valid <= issue;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      pa_valid <= p3_valid && p3_tag.last;
    end
  end

  always_ff @(posedge clk) begin
    p1_tag  <= tag0;
    p2_tag  <= p1_tag;
    p2_diff <= DIFF_W'(qry_rd) - DIFF_W'(ref_rd);
    p3_tag  <= p2_tag;
    p3_sq   <= SQ_W'(mag[COEF_WIDTH-1:0] * mag[COEF_WIDTH-1:0]);
    pa_tag  <= p3_tag;
    if (p3_valid) acc <= acc_next;
  end

  // running minimum, lowest index wins ties
  always_ff @(posedge clk) begin
    if (start) begin
      best_idx  <= '0;
      best_dist <= '0;
    end else if (pa_valid && ((pa_tag.ent == '0) || (acc < best_dist))) begin
      best_idx  <= pa_tag.ent;
      best_dist <= acc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst)
      out_valid <= 1'b0;
    else if (load_out)
      out_valid <= 1'b1;
    else if (m_axis_tready)
      out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx  <= IDX_W'(best_idx);
      out_dist <= best_dist;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {(OUT_DATA_W-DIST_W-IDX_W)'(0), out_dist, out_idx};

  // checks
  a_no_input_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (state == ST_IDLE))
    else $error("input taken while search busy");

  a_seq_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (seq_d <= dim_last) && (seq_e <= ent_last))
    else $error("sequencer beyond search bounds");

  a_final_in_drain: assert property (@(posedge clk) disable iff (rst)
    cmp_final |-> (state == ST_DRAIN))
    else $error("final compare outside drain");

  a_issue_only_search: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> ($past(state) == ST_SEARCH))
    else $error("pipeline fed outside search");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> m_axis_tvalid)
    else $error("result lost on load");

endmodule
